// ----- rtl/psfp_pkg.sv -----
// types and constants shared by the frame parser modules
`default_nettype none
package psfp_pkg;

  localparam logic [7:0] SIG_FIRST  = 8'h42;
  localparam logic [7:0] SIG_SECOND = 8'h4D;
  localparam logic [7:0] FRAME_LEN  = 8'd28;
  localparam logic [4:0] SUM_BYTES  = 5'd30;
  localparam logic [4:0] LAST_POS   = 5'd31;
  localparam logic [4:0] MEAS_FIRST = 5'd4;
  localparam logic [4:0] MEAS_LAST  = 5'd27;
  localparam int         NUM_MEAS   = 12;
  localparam int         IDX_W      = $clog2(NUM_MEAS);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_MEAS - 1);

  typedef enum logic [1:0] {
    ST_OK  = 2'd0,
    ST_SIG = 2'd1,
    ST_LEN = 2'd2,
    ST_SUM = 2'd3
  } status_t;

  typedef enum logic {
    S_RECV  = 1'b0,
    S_DRAIN = 1'b1
  } state_t;

  typedef struct packed {
    logic             take;
    logic             load_out;
    logic             clear_frame;
    logic [IDX_W-1:0] out_idx;
  } ctrl_cmd_t;

  typedef struct packed {
    logic final_byte;
    logic fault_none;
    logic out_free;
  } dp_status_t;

endpackage
`default_nettype wire

// ----- rtl/psfp_if.sv -----
// byte and result channel interfaces
`default_nettype none
interface psfp_byte_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [7:0] data_byte;

  modport source (output valid, output kind, output data_byte, input ready);
  modport sink   (input valid, input kind, input data_byte, output ready);
endinterface

interface psfp_result_if;
  logic        valid;
  logic        ready;
  logic [3:0]  field_index;
  logic [15:0] field_value;
  logic [1:0]  status;
  logic        last;

  modport source (output valid, output field_index, output field_value, output status,
                  output last, input ready);
  modport sink   (input valid, input field_index, input field_value, input status,
                  input last, output ready);
endinterface
`default_nettype wire

// ----- rtl/psfp_ctrl.sv -----
// frame parser controller: receive and drain sequencing
`default_nettype none
module psfp_ctrl (
  input  wire                     clk,
  input  wire                     rst,
  input  wire                     rx_valid,
  output logic                    rx_ready,
  input  psfp_pkg::dp_status_t    status,
  output psfp_pkg::ctrl_cmd_t     cmd
);
  import psfp_pkg::*;

  state_t           state, state_next;
  logic [IDX_W-1:0] idx, idx_next;
  logic             drain_done;

  assign drain_done = status.out_free && (!status.fault_none || idx == LAST_IDX);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_RECV;
      idx   <= '0;
    end else begin
      state <= state_next;
      idx   <= idx_next;
    end
  end

  always_comb begin
    state_next = state;
    idx_next   = idx;
    case (state)
      S_RECV: begin
        idx_next = '0;
        if (rx_valid && status.final_byte) state_next = S_DRAIN;
      end
      S_DRAIN: begin
        if (drain_done) begin
          state_next = S_RECV;
          idx_next   = '0;
        end else if (status.out_free) begin
          idx_next = idx + 1'b1;
        end
      end
      default: state_next = S_RECV;
    endcase
  end

  always_comb begin
    rx_ready         = 1'b0;
    cmd.take         = 1'b0;
    cmd.load_out     = 1'b0;
    cmd.clear_frame  = 1'b0;
    cmd.out_idx      = idx;
    case (state)
      S_RECV: begin
        rx_ready = 1'b1;
        cmd.take = rx_valid;
      end
      S_DRAIN: begin
        cmd.load_out    = status.out_free;
        cmd.clear_frame = drain_done;
      end
      default: ;
    endcase
  end

`ifndef NO_ASSERTIONS
  a_load_free: assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> status.out_free) else $error("result loaded into busy register");
  a_idx_range: assert property (@(posedge clk) disable iff (rst)
    state == S_DRAIN |-> idx <= LAST_IDX) else $error("drain index out of range");
  a_final_drain: assert property (@(posedge clk) disable iff (rst)
    (cmd.take && status.final_byte) |=> state == S_DRAIN)
    else $error("final byte did not start drain");
  a_no_take_drain: assert property (@(posedge clk) disable iff (rst)
    state == S_DRAIN |-> !cmd.take && !rx_ready) else $error("byte taken while draining");
`endif
endmodule
`default_nettype wire

// ----- rtl/psfp_dp.sv -----
// frame parser datapath: frame checks, measurement store, result register
`default_nettype none
module psfp_dp (
  input  wire                   clk,
  input  wire                   rst,
  input  psfp_pkg::ctrl_cmd_t   cmd,
  output psfp_pkg::dp_status_t  status,
  input  wire                   rx_kind,
  input  wire  [7:0]            rx_data_byte,
  output logic                  res_valid,
  input  wire                   res_ready,
  output logic [3:0]            res_field_index,
  output logic [15:0]           res_field_value,
  output logic [1:0]            res_status,
  output logic                  res_last
);
  import psfp_pkg::*;

  logic [4:0]       pos;
  logic [12:0]      sum;
  status_t          fault;
  logic [7:0]       pending;
  logic [15:0]      store [NUM_MEAS];

  logic [12:0]      sum_next;
  status_t          check;
  logic [4:0]       pos_off;
  logic [IDX_W-1:0] wr_idx;
  logic             take_data;

  assign take_data = cmd.take && !rx_kind;
  assign pos_off   = pos - MEAS_FIRST;
  assign wr_idx    = pos_off[IDX_W:1];
  assign sum_next  = (pos < SUM_BYTES) ? sum + {5'd0, rx_data_byte} : sum;

  always_comb begin
    check = ST_OK;
    case (pos)
      5'd0:      if (rx_data_byte != SIG_FIRST)  check = ST_SIG;
      5'd1:      if (rx_data_byte != SIG_SECOND) check = ST_SIG;
      5'd2:      if (rx_data_byte != 8'd0)       check = ST_LEN;
      5'd3:      if (rx_data_byte != FRAME_LEN)  check = ST_LEN;
      SUM_BYTES: if (rx_data_byte != {3'd0, sum[12:8]}) check = ST_SUM;
      LAST_POS:  if (rx_data_byte != sum[7:0])   check = ST_SUM;
      default:   check = ST_OK;
    endcase
  end

  assign status.final_byte = (pos == LAST_POS) && !rx_kind;
  assign status.fault_none = (fault == ST_OK);
  assign status.out_free   = !res_valid || res_ready;

  always_ff @(posedge clk) begin
    if (rst || cmd.clear_frame || (cmd.take && rx_kind)) begin
      pos     <= '0;
      sum     <= '0;
      fault   <= ST_OK;
      pending <= '0;
    end else if (take_data) begin
      sum <= sum_next;
      if (fault == ST_OK) fault <= check;
      if (pos != LAST_POS) pos <= pos + 1'b1;
      if (pos >= MEAS_FIRST && pos <= MEAS_LAST && !pos[0]) pending <= rx_data_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (take_data && pos >= MEAS_FIRST && pos <= MEAS_LAST && pos[0]) begin
      store[wr_idx] <= {pending, rx_data_byte};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (cmd.load_out) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      res_field_index <= status.fault_none ? 4'(cmd.out_idx) : 4'd0;
      res_field_value <= status.fault_none ? store[cmd.out_idx] : 16'd0;
      res_status      <= fault;
      res_last        <= !status.fault_none || cmd.out_idx == LAST_IDX;
    end
  end
endmodule
`default_nettype wire

// ----- rtl/particle_sensor_frame_parser.sv -----
// particulate sensor 32-byte frame parser, top level
// rx carries one item per transfer: kind 0 is a received byte, kind 1 drops
// any partial frame and restarts at byte 0 without producing a result.
// result carries (field_index, field_value, status, last) per transfer.
// while a frame is being received, one byte is taken every cycle.
// the 32nd byte starts a drain of the measurement store: a good frame gives
// twelve results, one per cycle while result.ready is high, the last one
// marked; a bad frame gives one result with the first failed check and a
// zero value. during the drain rx.ready is low; result.valid rises once the
// controller state register has entered the drain state and the output
// register has been loaded, in that order, after the final byte transfer.
// results pass through a single output register; if the receiver stalls,
// the drain waits and the held result stays stable.
// reset clears the frame position, running sum, fault and output valid;
// the measurement store is not cleared, every entry is rewritten by a frame
// before it is read.
`default_nettype none
module particle_sensor_frame_parser (
  input  wire            clk,
  input  wire            rst,
  psfp_byte_if.sink      rx,
  psfp_result_if.source  result
);
  import psfp_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t status;
  logic       rx_ready;

  assign rx.ready = rx_ready;

  psfp_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .rx_valid (rx.valid),
    .rx_ready (rx_ready),
    .status   (status),
    .cmd      (cmd)
  );

  psfp_dp u_dp (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .status          (status),
    .rx_kind         (rx.kind),
    .rx_data_byte    (rx.data_byte),
    .res_valid       (result.valid),
    .res_ready       (result.ready),
    .res_field_index (result.field_index),
    .res_field_value (result.field_value),
    .res_status      (result.status),
    .res_last        (result.last)
  );
endmodule
`default_nettype wire
